### rtl/ooff_pkg.sv
// Shared types and constants for the first odd occurrence finder
`default_nettype none
package ooff_pkg;

	localparam int VALUE_W       = 32;
	localparam int POS_W         = 8;
	localparam int MAX_ITEMS_DEF = 256;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last_item;
	} in_word_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             overflow;
	} out_word_t;

	// word travelling down the cell chain
	typedef struct packed {
		logic                      live;   // still looking for its cell
		logic                      tok;    // end-of-set marker, carries the search
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          pos;
		logic                      found;
		logic [POS_W-1:0]          fpos;
		logic                      ovf;
	} slot_t;

endpackage
`default_nettype wire

### rtl/ooff_cell.sv
// One cell of the chain: holds a distinct value, its first position and count parity
`default_nettype none
module ooff_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ooff_pkg::slot_t slot_in,
	output ooff_pkg::slot_t     slot_out
);
	import ooff_pkg::*;

	logic                      used_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [POS_W-1:0]          first_q;
	logic                      odd_q;
	slot_t                     slot_q;

	logic             match;
	logic             claim;
	logic             odd_now;
	logic             used_now;
	logic [POS_W-1:0] first_now;
	slot_t            slot_d;

	always_comb begin
		match     = slot_in.live && used_q && (val_q == slot_in.value);
		claim     = slot_in.live && !used_q;
		used_now  = used_q || claim;
		odd_now   = claim ? 1'b1 : (match ? !odd_q : odd_q);
		first_now = claim ? slot_in.pos : first_q;

		slot_d      = slot_in;
		slot_d.live = slot_in.live && !match && !claim;
		if (slot_in.tok && !slot_in.found && used_now && odd_now) begin
			slot_d.found = 1'b1;
			slot_d.fpos  = first_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			slot_q <= '0;
		end else begin
			used_q <= slot_in.tok ? 1'b0 : used_now;
			slot_q <= slot_d;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			val_q   <= slot_in.value;
			first_q <= slot_in.pos;
		end
		odd_q <= odd_now;
	end

	assign slot_out = slot_q;

endmodule
`default_nettype wire

### rtl/first_odd_occurrence_finder.sv
// Top level: entry counter and the chain of cells
// One word is taken every cycle; busy stays low. Each value runs down a chain of MAX_ITEMS
// cells, one cell per cycle, and settles in the first free cell or in the cell already
// holding the same value, whose parity it flips. The last word of a set drags the search
// and a clear behind it, so its result leaves the end of the chain on done for one cycle,
// after the input register and every cell in turn; the receiver cannot stall it. Sets
// may follow one another with no gap. Words beyond MAX_ITEMS in a set are dropped and flagged.
`default_nettype none
module first_odd_occurrence_finder #(
	parameter int MAX_ITEMS = ooff_pkg::MAX_ITEMS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire ooff_pkg::in_word_t  item,
	output logic                     busy,
	output logic                     done,
	output ooff_pkg::out_word_t      result
);
	import ooff_pkg::*;

	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             stored;
	logic             accept;
	slot_t            inject_d;
	slot_t            slot_w [MAX_ITEMS+1];
	slot_t            inject_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign stored = (cnt_q < CNT_W'(MAX_ITEMS));

	always_comb begin
		inject_d       = '0;
		inject_d.live  = accept && stored;
		inject_d.tok   = accept && item.last_item;
		inject_d.value = item.value;
		inject_d.pos   = POS_W'(cnt_q);
		inject_d.ovf   = ovf_q || !stored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			inject_q <= '0;
		end else begin
			inject_q <= inject_d;
			if (accept) begin
				if (item.last_item) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(stored);
					ovf_q <= ovf_q || !stored;
				end
			end
		end
	end

	assign slot_w[0] = inject_q;

	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		ooff_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot_in  (slot_w[g]),
			.slot_out (slot_w[g+1])
		);
	end

	assign done            = slot_w[MAX_ITEMS].tok;
	assign result.found    = slot_w[MAX_ITEMS].found;
	assign result.position = slot_w[MAX_ITEMS].fpos;
	assign result.overflow = slot_w[MAX_ITEMS].ovf;

	a_no_lost_value: assert property (@(posedge clk) disable iff (!arst_n)
		!slot_w[MAX_ITEMS].live)
		else $error("value left the chain without a cell");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ITEMS))
		else $error("entry count beyond capacity");

	a_set_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.last_item |=> cnt_q == '0 && !ovf_q)
		else $error("set state not cleared after last word");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.position == '0)
		else $error("position non-zero without a find");

	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !stored |=> inject_q.ovf && !inject_q.live)
		else $error("dropped word not flagged");

endmodule
`default_nettype wire
